// ----- rtl/core/ole_pkg.sv -----
// package for the ordered list engine: opcodes, status codes and sizes
package ole_pkg;
    localparam int unsigned DEFAULT_DEPTH = 16;
    localparam int unsigned MAX_OUT       = 16;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_RM_FRONT  = 3'd3,
        OP_RM_BACK   = 3'd4,
        OP_RM_VALUE  = 3'd5,
        OP_RD_FWD    = 3'd6,
        OP_RD_REV    = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;
endpackage

// ----- rtl/core/ordered_list_engine.sv -----
// ordered list engine: doubly linked list of signed values in a node memory
//
//  channel | handshake          | fields
//  --------+--------------------+--------------------------------------------
//  command | i_start / o_busy   | i_opcode, i_position, i_value
//  result  | o_valid (strobe)   | o_status, o_data_out, o_count_out,
//          |                    | o_last_result
//
// sequencing: a command is taken when i_start is high and o_busy is low. The node
// memory has a registered read, so each link followed takes an address state
// and then a wait state for the registered data. A readout gives one result
// per node visited, each after its read and wait states, up to MAX_OUT nodes;
// an insert or removal also walks or searches node by node, and each
// neighbour fix-up is a read, a wait and a write.
// reset: synchronous, active low; head and tail go to the null marker, the
// count to zero and the free stack is filled by a sweep over all DEPTH slots, busy high
// stalls: the receiver cannot stall; each result is shown for one cycle.
module ordered_list_engine #(
    parameter int unsigned DEPTH = ole_pkg::DEFAULT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [2:0]                   i_opcode,
    input  logic [4:0]                   i_position,
    input  logic signed [31:0]           i_value,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic signed [31:0]           o_data_out,
    output logic [4:0]                   o_count_out,
    output logic                         o_last_result
);
    import ole_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);      // node index width
    localparam int unsigned LW = $clog2(DEPTH + 1);  // link width incl. null
    localparam int unsigned IXW = (LW > 5) ? LW : 5; // walk and readout counter
    localparam logic [LW-1:0] NIL = LW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_WALK_RD, S_WALK_WT, S_LINK_RD, S_LINK_WT,
        S_LINK_WR, S_UNL_RD, S_UNL_WT, S_UNL_WR, S_SRCH_RD, S_SRCH_WT,
        S_OUT_RD, S_OUT_WT, S_DONE
    } t_state;

    // node memory: value, next and prev in one word
    typedef struct packed {
        logic [31:0]   val;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } t_node;

    t_node         mem [DEPTH];
    logic [IW-1:0] free_mem [DEPTH];

    t_state        r_state;
    logic [LW-1:0] r_head, r_tail, r_count, r_free_top;
    logic [2:0]    r_op;
    logic [4:0]    r_pos;
    logic [31:0]   r_val;
    logic [LW-1:0] r_cur, r_at, r_prv, r_nxt;
    logic [IW-1:0] r_node;
    logic [IXW-1:0] r_idx;
    logic [2:0]    r_fix;     // fix-up step counter for link/unlink writes
    t_node         r_rd;
    logic [IW-1:0] r_free_rd;
    logic          r_init;    // free stack initialisation sweep
    logic [IW-1:0] r_init_idx;

    // memory write port (one write a cycle)
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_node         mem_wd;
    logic [IW-1:0] mem_ra;

    logic          r_valid_o;
    logic [2:0]    r_st_o;
    logic [31:0]   r_data_o;
    logic          r_last_o;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
        r_free_rd <= free_mem[IW'(r_free_top - LW'(1))];
    end

    // free stack pushes come from the state machine, init from the sweep
    logic          fs_we;
    logic [IW-1:0] fs_wa, fs_wd;
    always_ff @(posedge i_clk) begin
        if (fs_we) free_mem[fs_wa] <= fs_wd;
    end

    logic [IW-1:0] cur_ix;
    assign cur_ix = r_cur[IW-1:0];

    // readout: next node in readout order and whether this one is the last
    logic [LW-1:0] out_nxt;
    logic          out_last;
    assign out_nxt  = (t_opcode'(r_op) == OP_RD_FWD) ? r_rd.nxt : r_rd.prv;
    assign out_last = (out_nxt == NIL) ||
                      (r_idx + IXW'(1) == IXW'(MAX_OUT)) ||
                      ((IXW+1)'(r_idx) + (IXW+1)'(1) == (IXW+1)'(r_count));

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_node;
        mem_wd = '0;
        mem_ra = cur_ix;
        fs_we  = 1'b0;
        fs_wa  = r_init_idx;
        fs_wd  = r_init_idx;
        if (r_init) begin
            fs_we = 1'b1;
        end else begin
            case (r_state)
                S_LINK_WR: begin
                    // step 0 new node, 1 prev node next, 2 at node prev
                    mem_we = 1'b1;
                    if (r_fix == 3'd0) begin
                        mem_wa = r_node;
                        mem_wd = '{val: r_val, nxt: r_at, prv: r_prv};
                    end else if (r_fix == 3'd1) begin
                        mem_wa = r_prv[IW-1:0];
                        mem_wd = r_rd;
                        mem_wd.nxt = LW'(r_node);
                    end else begin
                        mem_wa = r_at[IW-1:0];
                        mem_wd = r_rd;
                        mem_wd.prv = LW'(r_node);
                    end
                end
                S_UNL_WR: begin
                    mem_we = 1'b1;
                    if (r_fix == 3'd1) begin
                        mem_wa = r_prv[IW-1:0];
                        mem_wd = r_rd;
                        mem_wd.nxt = r_nxt;
                    end else begin
                        mem_wa = r_nxt[IW-1:0];
                        mem_wd = r_rd;
                        mem_wd.prv = r_prv;
                    end
                    if (r_fix == 3'd3) begin
                        mem_we = 1'b0;
                        fs_we  = 1'b1;
                        fs_wa  = r_free_top[IW-1:0];
                        fs_wd  = r_node;
                    end
                end
                // neighbour address held through the wait cycle
                S_LINK_RD, S_LINK_WT:
                    mem_ra = (r_fix == 3'd1) ? r_prv[IW-1:0] : r_at[IW-1:0];
                S_UNL_RD, S_UNL_WT:
                    mem_ra = (r_fix == 3'd1) ? r_prv[IW-1:0] : r_nxt[IW-1:0];
                default:   mem_ra = cur_ix;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_init;
    assign o_valid = r_valid_o;
    assign o_status = r_st_o;
    assign o_data_out = r_data_o;
    assign o_count_out = 5'(r_count);
    assign o_last_result = r_last_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= NIL;
            r_tail     <= NIL;
            r_count    <= '0;
            r_free_top <= LW'(DEPTH);
            r_init     <= 1'b1;
            r_init_idx <= '0;
            r_valid_o  <= 1'b0;
        end else begin
            r_valid_o <= 1'b0;
            if (r_init) begin
                r_init_idx <= r_init_idx + IW'(1);
                if (r_init_idx == IW'(DEPTH - 1)) r_init <= 1'b0;
            end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op  <= i_opcode;
                        r_pos <= i_position;
                        r_val <= i_value;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    r_fix <= '0;
                    r_data_o <= '0;
                    r_last_o <= 1'b1;
                    case (t_opcode'(r_op))
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                            if (t_opcode'(r_op) == OP_INS_FRONT) r_pos <= '0;
                            if (t_opcode'(r_op) == OP_INS_BACK) r_pos <= 5'(r_count);
                            if (t_opcode'(r_op) == OP_INS_POS &&
                                    (IXW+1)'(r_pos) > (IXW+1)'(r_count)) begin
                                r_st_o <= ST_BAD_POS;
                                r_state <= S_DONE;
                            end else if (r_count >= LW'(DEPTH) || r_free_top == '0) begin
                                r_st_o <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_st_o <= ST_OK;
                                r_node <= r_free_rd;
                                r_free_top <= r_free_top - LW'(1);
                                if (t_opcode'(r_op) == OP_INS_BACK) begin
                                    r_at <= NIL;
                                    r_prv <= r_tail;
                                    r_state <= S_LINK_WR;
                                end else begin
                                    r_cur <= r_head;
                                    r_state <= S_WALK_RD;
                                end
                            end
                        end
                        OP_RM_FRONT, OP_RM_BACK, OP_RM_VALUE: begin
                            if (r_count == '0) begin
                                r_st_o <= ST_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_st_o <= ST_OK;
                                r_cur <= (t_opcode'(r_op) == OP_RM_BACK) ? r_tail : r_head;
                                r_state <= S_SRCH_RD;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                r_st_o <= ST_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_st_o <= ST_OK;
                                r_cur <= (t_opcode'(r_op) == OP_RD_FWD) ? r_head : r_tail;
                                r_state <= S_OUT_RD;
                            end
                        end
                    endcase
                end
                S_WALK_RD: begin
                    if (r_idx == IXW'(r_pos) || r_cur == NIL) begin
                        r_at <= r_cur;
                        if (r_cur == NIL) begin
                            r_prv <= r_tail;
                            r_state <= S_LINK_WR;
                        end else r_state <= S_WALK_WT;
                    end else r_state <= S_WALK_WT;
                end
                S_WALK_WT: begin
                    if (r_idx == IXW'(r_pos)) begin
                        r_prv <= r_rd.prv;
                        r_state <= S_LINK_WR;
                    end else begin
                        r_cur <= r_rd.nxt;
                        r_idx <= r_idx + IXW'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_LINK_WR: begin
                    if (r_fix == 3'd0) begin
                        r_count <= r_count + LW'(1);
                        if (r_prv == NIL) r_head <= LW'(r_node);
                        if (r_at == NIL) r_tail <= LW'(r_node);
                        if (r_prv != NIL) begin
                            r_fix <= 3'd1;
                            r_state <= S_LINK_RD;
                        end else if (r_at != NIL) begin
                            r_fix <= 3'd2;
                            r_state <= S_LINK_RD;
                        end else r_state <= S_DONE;
                    end else if (r_fix == 3'd1 && r_at != NIL) begin
                        r_fix <= 3'd2;
                        r_state <= S_LINK_RD;
                    end else r_state <= S_DONE;
                end
                S_LINK_RD: r_state <= S_LINK_WT;
                S_LINK_WT: r_state <= S_LINK_WR;
                S_SRCH_RD: begin
                    if (r_cur == NIL || r_idx == IXW'(DEPTH)) begin
                        r_st_o <= ST_NOT_FOUND;
                        r_state <= S_DONE;
                    end else r_state <= S_SRCH_WT;
                end
                S_SRCH_WT: begin
                    if (t_opcode'(r_op) != OP_RM_VALUE || r_rd.val == r_val) begin
                        r_node <= cur_ix;
                        r_prv <= r_rd.prv;
                        r_nxt <= r_rd.nxt;
                        if (r_rd.prv == NIL) r_head <= r_rd.nxt;
                        if (r_rd.nxt == NIL) r_tail <= r_rd.prv;
                        r_count <= r_count - LW'(1);
                        if (r_rd.prv != NIL) begin
                            r_fix <= 3'd1;
                            r_state <= S_UNL_RD;
                        end else if (r_rd.nxt != NIL) begin
                            r_fix <= 3'd2;
                            r_state <= S_UNL_RD;
                        end else begin
                            r_fix <= 3'd3;
                            r_state <= S_UNL_WR;
                        end
                    end else begin
                        r_cur <= r_rd.nxt;
                        r_idx <= r_idx + IXW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_UNL_RD: r_state <= S_UNL_WT;
                S_UNL_WT: r_state <= S_UNL_WR;
                S_UNL_WR: begin
                    if (r_fix == 3'd1 && r_nxt != NIL) begin
                        r_fix <= 3'd2;
                        r_state <= S_UNL_RD;
                    end else if (r_fix != 3'd3) begin
                        r_fix <= 3'd3;
                    end else begin
                        if (r_free_top < LW'(DEPTH)) r_free_top <= r_free_top + LW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_WT;
                S_OUT_WT: begin
                    r_valid_o <= 1'b1;
                    r_data_o <= r_rd.val;
                    r_last_o <= out_last;
                    r_cur <= out_nxt;
                    r_idx <= r_idx + IXW'(1);
                    r_state <= out_last ? S_IDLE : S_OUT_RD;
                end
                S_DONE: begin
                    r_valid_o <= 1'b1;
                    r_data_o <= '0;
                    r_last_o <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(DEPTH)) else $error("count beyond depth");
    a_empty_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && r_state == S_IDLE) |-> (r_head == NIL && r_tail == NIL))
        else $error("empty list with live head or tail");
    a_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_init) |-> (r_count + r_free_top == LW'(DEPTH)))
        else $error("node pool leak");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_result) |-> o_busy) else $error("readout left early");
`endif
endmodule
